// ===== src/ptc_pkg.sv =====
package ptc_pkg;

    localparam int SAMPLE_BITS_DEF     = 20;
    localparam int MAX_CAL_SAMPLES_DEF = 4096;
    localparam int FRAC_BITS_DEF       = 8;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [15:0] FACTOR_RESET = 16'd768;
    localparam logic [23:0] THR_MAX      = 24'hFFFFFF;
    localparam logic [23:0] THR_RESET    = 24'd40000;

    typedef enum logic [2:0] {
        CFG_FACTOR     = 3'd0,
        CFG_INIT_THR   = 3'd1,
        CFG_SAMPLE_PER = 3'd2,
        CFG_DEBOUNCE   = 3'd3,
        CFG_CAL_DUR    = 3'd4,
        CFG_CAL_PER    = 3'd5,
        CFG_CAL_MIN    = 3'd6,
        CFG_UNUSED     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_START  = 3'd1,
        FN_CANCEL = 3'd2,
        FN_REAPPLY = 3'd3,
        FN_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STARTED = 2'd1,
        EV_DONE    = 2'd2,
        EV_FAILED  = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV_MEAN,
        ST_VAR_PREP,
        ST_DIV_VAR,
        ST_SQRT,
        ST_THR_MUL,
        ST_THR_FIN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic tick;        // apply tick, command and sample step
        logic mean_start;
        logic var_start;
        logic sqrt_start;
        logic thr_mul;     // threshold multiply, before each tick and after a finish
        logic thr_fin;     // round, clamp, apply
        logic fin_ok;      // store stats on finish
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_finish;  // tick ended a run with enough samples
        logic div_done;
        logic sqrt_done;
    } ctl_sts_t;

endpackage

// ===== src/ptc_if.sv =====
interface ptc_in_if #(parameter int SAMPLE_BITS = 20);
    logic                   valid;
    logic                   ready;
    logic [2:0]             func;
    logic [SAMPLE_BITS-1:0] raw_sample;
    modport source (output valid, func, raw_sample, input ready);
    modport sink   (input valid, func, raw_sample, output ready);
endinterface

interface ptc_out_if;
    logic        valid;
    logic        ready;
    logic        present;
    logic        raw_present;
    logic        calibrating;
    logic [1:0]  event_res;
    logic [23:0] threshold_now;
    logic [27:0] mean_q8;
    logic [27:0] stddev_q8;
    logic [12:0] cal_samples_taken;
    logic        cal_ok;
    modport source (output valid, present, raw_present, calibrating, event_res,
                    threshold_now, mean_q8, stddev_q8, cal_samples_taken, cal_ok,
                    input ready);
    modport sink   (input valid, present, raw_present, calibrating, event_res,
                    threshold_now, mean_q8, stddev_q8, cal_samples_taken, cal_ok,
                    output ready);
endinterface

interface ptc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/presence_threshold_calibrator_core.sv =====
// plain tick: accepted in IDLE, then THR_MUL and TICK states, result valid in OUT
// calibration end: two 80-step divisions (mean, then variance) and a 32-step root
// one item at a time: no new input is taken until the result has been taken
// reset: rst_n asynchronous active low, clears control state, loads register defaults
module presence_threshold_calibrator_core #(
    parameter int SAMPLE_BITS     = ptc_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CAL_SAMPLES = ptc_pkg::MAX_CAL_SAMPLES_DEF,
    parameter int FRAC_BITS       = ptc_pkg::FRAC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    ptc_in_if.sink    in_ch,
    ptc_out_if.source out_ch,
    ptc_cfg_if.sink   cfg
);

    import ptc_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic     in_fire, out_fire, cfg_fire;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_ch.valid & out_ch.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;

    ptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    ptc_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES),
        .FRAC_BITS       (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_fire           (in_fire),
        .func              (in_ch.func),
        .raw_sample        (in_ch.raw_sample),
        .cfg_fire          (cfg_fire),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .cmd               (cmd),
        .sts               (sts),
        .present           (out_ch.present),
        .raw_present       (out_ch.raw_present),
        .calibrating       (out_ch.calibrating),
        .event_res         (out_ch.event_res),
        .threshold_now     (out_ch.threshold_now),
        .mean_q8           (out_ch.mean_q8),
        .stddev_q8         (out_ch.stddev_q8),
        .cal_samples_taken (out_ch.cal_samples_taken),
        .cal_ok            (out_ch.cal_ok)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while result pending");
    a_thr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.threshold_now != 24'd0)
        else $error("threshold is zero");
    a_ok_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.cal_ok) |-> (out_ch.mean_q8 == 28'd0))
        else $error("mean shown without a good calibration");
`endif

endmodule

// ===== src/ptc_divider.sv =====
module ptc_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[W-1]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== src/ptc_sqrt.sv =====
module ptc_sqrt #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] radicand,
    output logic [W-1:0] root,
    output logic         done
);

    localparam int CW = $clog2(W / 2 + 1);

    logic [W-1:0]  v_reg, v_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  bit_reg, bit_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    rb;

    // digit-by-digit root, one result bit a cycle, rounded at the end
    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rb        = {1'b0, r_reg} + {1'b0, bit_reg};
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            bit_next  = W'(1) << (W - 2);
            cnt_next  = CW'(W / 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= rb)
            begin
                v_next = W'({1'b0, v_reg} - rb);
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg)
        begin
            // final round to nearest
            if (v_reg > r_reg)
            begin
                r_next = r_reg + W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    // root is valid the cycle after done, once rounding is applied
    assign root = r_reg;
    assign done = done_reg;

endmodule

// ===== src/ptc_ctrl.sv =====
module ptc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  ptc_pkg::ctl_sts_t sts,
    output ptc_pkg::ctl_cmd_t cmd,
    output logic              in_ready,
    output logic              out_valid
);

    import ptc_pkg::*;

    state_t state_reg, state_next;
    logic   sqrt_wait_reg, sqrt_wait_next;
    logic   fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sqrt_wait_reg <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sqrt_wait_reg <= sqrt_wait_next;
            fin_reg       <= fin_next;
        end
    end

    // sequencer: threshold product, tick, optional finish, then present result
    always_comb
    begin
        state_next     = state_reg;
        sqrt_wait_next = sqrt_wait_reg;
        fin_next       = fin_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    fin_next   = 1'b0;
                    state_next = ST_THR_MUL;
                end
            end
            ST_TICK:
            begin
                cmd.tick = 1'b1;
                if (sts.need_finish)
                begin
                    cmd.mean_start = 1'b1;
                    fin_next       = 1'b1;
                    state_next     = ST_DIV_MEAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_MEAN:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_VAR_PREP;
                end
            end
            ST_VAR_PREP:
            begin
                state_next    = ST_DIV_VAR;
                cmd.var_start = 1'b1;
            end
            ST_DIV_VAR:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    sqrt_wait_next = 1'b0;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_wait_reg)
                begin
                    cmd.fin_ok = 1'b1;
                    state_next = ST_THR_MUL;
                end
                else if (sts.sqrt_done)
                begin
                    sqrt_wait_next = 1'b1;
                end
            end
            ST_THR_MUL:
            begin
                cmd.thr_mul = 1'b1;
                state_next  = fin_reg ? ST_THR_FIN : ST_TICK;
            end
            ST_THR_FIN:
            begin
                cmd.thr_fin = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ptc_datapath.sv =====
module ptc_datapath #(
    parameter int SAMPLE_BITS     = ptc_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CAL_SAMPLES = ptc_pkg::MAX_CAL_SAMPLES_DEF,
    parameter int FRAC_BITS       = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic [2:0]                        func,
    input  logic [SAMPLE_BITS-1:0]            raw_sample,
    input  logic                              cfg_fire,
    input  logic [ptc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ptc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  ptc_pkg::ctl_cmd_t                 cmd,
    output ptc_pkg::ctl_sts_t                 sts,
    output logic                              present,
    output logic                              raw_present,
    output logic                              calibrating,
    output logic [1:0]                        event_res,
    output logic [23:0]                       threshold_now,
    output logic [27:0]                       mean_q8,
    output logic [27:0]                       stddev_q8,
    output logic [12:0]                       cal_samples_taken,
    output logic                              cal_ok
);

    import ptc_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
    localparam int SQ_BITS  = 2 * SAMPLE_BITS + CNT_BITS;
    localparam int DW       = 64;
    localparam int DIV_W    = DW + 2 * FRAC_BITS;
    localparam int RND_SH   = FRAC_BITS + 8;

    // configuration
    logic [15:0] factor_reg;
    logic [23:0] init_thr_reg;
    logic [15:0] sample_per_reg, debounce_reg, cal_dur_reg, cal_per_reg;
    logic [12:0] cal_min_reg;

    // detection and calibration state
    logic [23:0]            threshold_reg;
    logic [SAMPLE_BITS-1:0] last_raw_reg;
    logic                   raw_level_reg, present_level_reg;
    logic [15:0]            sample_timer_reg, change_timer_reg;
    logic                   cal_active_reg, cal_first_reg;
    logic [15:0]            cal_elapsed_reg, cal_stimer_reg;
    logic [CNT_BITS-1:0]    cal_count_reg;
    logic [SUM_BITS-1:0]    cal_sum_reg;
    logic [SQ_BITS-1:0]     cal_sq_reg;
    logic                   stats_valid_reg, last_ok_reg;
    logic [27:0]            mean_reg, sd_reg;
    logic [12:0]            last_samples_reg;
    logic [1:0]             ev_reg;
    logic [2:0]             func_reg;
    logic [SAMPLE_BITS-1:0] x_reg;

    // finish path
    logic [DIV_W-1:0] div_a, div_b, div_q, div_r;
    logic             div_start, div_done;
    logic [DW-1:0]    sq_root;
    logic             sq_done;
    logic [DW-1:0]    nn_reg, mean_calc_reg, d_reg;
    logic [DW-1:0]    thr_acc_reg;
    logic [DW-1:0]    thr_r;
    logic [23:0]      thr_sel;
    logic             var_phase_reg;

    // tick combinational results
    logic [15:0]            st_n, ct_n, ce_n, cs_n;
    logic                   act_n, first_n, raw_n, pres_n, sv_n, lok_n;
    logic [23:0]            thr_n;
    logic [SAMPLE_BITS-1:0] lr_n;
    logic [CNT_BITS-1:0]    cnt_n;
    logic [SUM_BITS-1:0]    sum_n;
    logic [SQ_BITS-1:0]     sq_n;
    logic [27:0]            mean_n, sd_n;
    logic [12:0]            ls_n;
    logic [1:0]             ev_n;
    logic                   need_fin;
    logic                   cand;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // capture item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            x_reg    <= raw_sample;
        end
    end

    // threshold from stored stats, rounded and clamped
    assign thr_r   = (thr_acc_reg + (DW'(1) << (RND_SH - 1))) >> RND_SH;
    assign thr_sel = (thr_r == '0) ? 24'd1 :
                     (thr_r > DW'(THR_MAX)) ? THR_MAX : thr_r[23:0];

    // tick step: timers, command, then detection or calibration
    always_comb
    begin
        st_n = sat_inc(sample_timer_reg);
        ct_n = sat_inc(change_timer_reg);
        ce_n = cal_elapsed_reg;
        cs_n = cal_stimer_reg;
        act_n = cal_active_reg;
        first_n = cal_first_reg;
        raw_n = raw_level_reg;
        pres_n = present_level_reg;
        sv_n = stats_valid_reg;
        lok_n = last_ok_reg;
        thr_n = threshold_reg;
        lr_n = last_raw_reg;
        cnt_n = cal_count_reg;
        sum_n = cal_sum_reg;
        sq_n = cal_sq_reg;
        mean_n = mean_reg;
        sd_n = sd_reg;
        ls_n = last_samples_reg;
        ev_n = EV_NONE;
        need_fin = 1'b0;
        cand = 1'b0;
        if (cal_active_reg)
        begin
            ce_n = sat_inc(cal_elapsed_reg);
            cs_n = sat_inc(cal_stimer_reg);
        end
        case (func_reg)
            FN_START:
            begin
                if (!cal_active_reg)
                begin
                    act_n = 1'b1;
                    ce_n = '0;
                    cs_n = '0;
                    first_n = 1'b1;
                    cnt_n = '0;
                    sum_n = '0;
                    sq_n = '0;
                    ev_n = EV_STARTED;
                end
            end
            FN_CANCEL:
            begin
                act_n = 1'b0;
            end
            FN_REAPPLY:
            begin
                // threshold product was formed the cycle before
                if (stats_valid_reg)
                begin
                    thr_n = thr_sel;
                    raw_n = {4'd0, last_raw_reg} > thr_sel;
                    pres_n = raw_n;
                    ct_n = '0;
                end
            end
            FN_CLEAR:
            begin
                sv_n = 1'b0;
                mean_n = '0;
                sd_n = '0;
                thr_n = init_thr_reg;
                raw_n = {4'd0, last_raw_reg} > init_thr_reg;
                pres_n = raw_n;
                ct_n = '0;
            end
            default:
            begin
            end
        endcase
        if (act_n)
        begin
            if (ce_n >= cal_dur_reg)
            begin
                act_n = 1'b0;
                ls_n = 13'(cnt_n);
                if (cnt_n == '0 || 13'(cnt_n) < cal_min_reg)
                begin
                    lok_n = 1'b0;
                    ev_n = EV_FAILED;
                end
                else
                begin
                    need_fin = 1'b1;
                    ev_n = EV_DONE;
                end
            end
            else if (first_n || cs_n >= cal_per_reg)
            begin
                first_n = 1'b0;
                cs_n = '0;
                lr_n = x_reg;
                if (cnt_n < CNT_BITS'(MAX_CAL_SAMPLES))
                begin
                    cnt_n = cnt_n + CNT_BITS'(1);
                    sum_n = sum_n + SUM_BITS'(x_reg);
                end
            end
        end
        else if (st_n >= sample_per_reg)
        begin
            st_n = '0;
            lr_n = x_reg;
            cand = {4'd0, x_reg} > thr_n;
            if (cand != raw_n)
            begin
                raw_n = cand;
                ct_n = '0;
            end
            if (ct_n >= debounce_reg)
            begin
                pres_n = raw_n;
            end
        end
    end

    // square of the sample, registered, added to the sum of squares in the cycle after the tick
    logic [2*SAMPLE_BITS-1:0] xsq_reg;
    logic                     sq_add_reg;
    always_ff @(posedge clk)
    begin
        xsq_reg <= x_reg * x_reg;
    end

    // finish arithmetic setup, variance dividend carries the 2F fraction bits
    logic [DW-1:0] nsq_reg, s2_reg;
    always_comb
    begin
        div_start = cmd.mean_start | cmd.var_start;
        if (cmd.var_start)
        begin
            div_a = {d_reg, {(2 * FRAC_BITS){1'b0}}};
            div_b = DIV_W'(nn_reg);
        end
        else
        begin
            div_a = DIV_W'({cal_sum_reg, FRAC_BITS'(0)}) + DIV_W'(cal_count_reg >> 1);
            div_b = DIV_W'(cal_count_reg);
        end
    end

    ptc_divider #(.W(DIV_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    ptc_sqrt #(.W(DW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (DW'(div_q)),
        .root     (sq_root),
        .done     (sq_done)
    );

    always_ff @(posedge clk)
    begin
        // products for the variance while the mean divides
        if (cmd.mean_start)
        begin
            nsq_reg <= DW'(cal_count_reg) * DW'(cal_sq_reg);
            s2_reg  <= DW'(cal_sum_reg) * DW'(cal_sum_reg);
            nn_reg  <= DW'(cal_count_reg) * DW'(cal_count_reg);
        end
        if (div_done && !var_phase_reg)
        begin
            mean_calc_reg <= DW'(div_q);
        end
        if (cmd.thr_mul)
        begin
            thr_acc_reg <= DW'({mean_reg, 8'd0}) + DW'(factor_reg) * DW'(sd_reg);
        end
    end

    assign d_reg = (nsq_reg > s2_reg) ? nsq_reg - s2_reg : '0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
            init_thr_reg <= THR_RESET;
            sample_per_reg <= 16'd50;
            debounce_reg <= 16'd200;
            cal_dur_reg <= 16'd5000;
            cal_per_reg <= 16'd20;
            cal_min_reg <= 13'd10;
            threshold_reg <= THR_RESET;
            last_raw_reg <= '0;
            raw_level_reg <= 1'b0;
            present_level_reg <= 1'b0;
            sample_timer_reg <= '0;
            change_timer_reg <= '0;
            cal_active_reg <= 1'b0;
            cal_first_reg <= 1'b0;
            cal_elapsed_reg <= '0;
            cal_stimer_reg <= '0;
            cal_count_reg <= '0;
            cal_sum_reg <= '0;
            cal_sq_reg <= '0;
            stats_valid_reg <= 1'b0;
            last_ok_reg <= 1'b0;
            mean_reg <= '0;
            sd_reg <= '0;
            last_samples_reg <= '0;
            ev_reg <= EV_NONE;
            var_phase_reg <= 1'b0;
            sq_add_reg <= 1'b0;
        end
        else
        begin
            sq_add_reg <= 1'b0;
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FACTOR:     factor_reg <= cfg_data[15:0];
                    CFG_INIT_THR:   init_thr_reg <= cfg_data;
                    CFG_SAMPLE_PER: sample_per_reg <= cfg_data[15:0];
                    CFG_DEBOUNCE:   debounce_reg <= cfg_data[15:0];
                    CFG_CAL_DUR:    cal_dur_reg <= cfg_data[15:0];
                    CFG_CAL_PER:    cal_per_reg <= cfg_data[15:0];
                    CFG_CAL_MIN:    cal_min_reg <= cfg_data[12:0];
                    default:        ;
                endcase
            end
            if (cmd.tick)
            begin
                sample_timer_reg <= st_n;
                change_timer_reg <= ct_n;
                cal_elapsed_reg <= ce_n;
                cal_stimer_reg <= cs_n;
                cal_active_reg <= act_n;
                cal_first_reg <= first_n;
                raw_level_reg <= raw_n;
                present_level_reg <= pres_n;
                stats_valid_reg <= sv_n;
                last_ok_reg <= lok_n;
                threshold_reg <= thr_n;
                last_raw_reg <= lr_n;
                cal_count_reg <= cnt_n;
                cal_sum_reg <= sum_n;
                cal_sq_reg <= sq_n;
                mean_reg <= mean_n;
                sd_reg <= sd_n;
                last_samples_reg <= ls_n;
                ev_reg <= ev_n;
                var_phase_reg <= 1'b0;
                if (func_reg == FN_CLEAR)
                begin
                    factor_reg <= FACTOR_RESET;
                end
                sq_add_reg <= (cnt_n != cal_count_reg) && (func_reg != FN_START
                              || cal_active_reg) ? 1'b1 : (cnt_n != '0 && func_reg
                              == FN_START && !cal_active_reg);
            end
            if (sq_add_reg)
            begin
                cal_sq_reg <= cal_sq_reg + SQ_BITS'(xsq_reg);
            end
            if (cmd.var_start)
            begin
                var_phase_reg <= 1'b1;
            end
            if (cmd.fin_ok)
            begin
                mean_reg <= 28'(mean_calc_reg);
                sd_reg <= 28'(sq_root);
                stats_valid_reg <= 1'b1;
                last_ok_reg <= 1'b1;
            end
            if (cmd.thr_fin)
            begin
                threshold_reg <= thr_sel;
                raw_level_reg <= {4'd0, last_raw_reg} > thr_sel;
                present_level_reg <= {4'd0, last_raw_reg} > thr_sel;
                change_timer_reg <= '0;
            end
        end
    end

    assign sts.need_finish  = need_fin;
    assign sts.div_done     = div_done;
    assign sts.sqrt_done    = sq_done;

    assign present           = present_level_reg;
    assign raw_present       = raw_level_reg;
    assign calibrating       = cal_active_reg;
    assign event_res         = ev_reg;
    assign threshold_now     = threshold_reg;
    assign mean_q8           = last_ok_reg ? mean_reg : '0;
    assign stddev_q8         = last_ok_reg ? sd_reg : '0;
    assign cal_samples_taken = last_samples_reg;
    assign cal_ok            = last_ok_reg;

endmodule

// ===== sim/presence_threshold_calibrator_core_test.sv =====
`timescale 1ns / 100ps

module presence_threshold_calibrator_core_test;
    import ptc_pkg::*;

    logic clk;
    logic rst_n;

    ptc_in_if #(.SAMPLE_BITS(20)) in_ch ();
    ptc_out_if out_ch ();
    ptc_cfg_if cfg ();

    presence_threshold_calibrator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg(cfg)
    );

    typedef struct packed {
        logic [2:0]  func;
        logic [19:0] sample;
    } tick_item_t;

    typedef struct packed {
        logic        present;
        logic        raw_present;
        logic        calibrating;
        logic [1:0]  event_res;
        logic [23:0] threshold_now;
        logic [27:0] mean_q8;
        logic [27:0] stddev_q8;
        logic [12:0] cal_samples_taken;
        logic        cal_ok;
    } status_t;

    // predictor configuration
    logic [15:0] p_factor, p_sper, p_deb, p_cdur, p_cper;
    logic [23:0] p_init_thr;
    logic [12:0] p_cmin;

    // predictor state
    logic [23:0] p_thr;
    logic [19:0] p_last_raw;
    logic        p_raw_lvl, p_pres_lvl;
    logic [15:0] p_samp_tmr, p_chg_tmr, p_cal_el, p_cal_tmr;
    logic        p_cal_act, p_cal_first;
    logic [12:0] p_cal_cnt;
    logic [32:0] p_sum;
    logic [52:0] p_sumsq;
    logic        p_stats_valid, p_last_ok;
    logic [27:0] p_mean, p_sd;
    logic [12:0] p_last_n;

    tick_item_t pending_ticks[$];
    status_t    expected_status[$];
    int         errors;
    int         accepted_in;
    int         driven_cnt = 0;
    int         results_seen;
    int         idle_pct;
    int         stall_cycles;
    int         cal_done_seen;
    int         cal_fail_seen;

    function automatic logic [15:0] sat16(logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic logic [63:0] root_rounded(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (v > r) r = r + 1;
        return r;
    endfunction

    function automatic logic [23:0] thr_of(logic [27:0] m, logic [27:0] s, logic [15:0] f);
        logic [63:0] t;
        t = ({36'd0, m} << 8) + {48'd0, f} * {36'd0, s};
        t = (t + (64'd1 << 15)) >> 16;
        if (t < 1) t = 1;
        if (t > 64'hFFFFFF) t = 64'hFFFFFF;
        return t[23:0];
    endfunction

    function automatic void set_thr(logic [23:0] t);
        p_thr      = t;
        p_raw_lvl  = p_last_raw > t;
        p_pres_lvl = p_raw_lvl;
        p_chg_tmr  = 0;
    endfunction

    task automatic reset_predictor();
        p_factor = FACTOR_RESET; p_init_thr = THR_RESET; p_sper = 50; p_deb = 200;
        p_cdur = 5000; p_cper = 20; p_cmin = 10;
        p_thr = THR_RESET; p_last_raw = 0; p_raw_lvl = 0; p_pres_lvl = 0;
        p_samp_tmr = 0; p_chg_tmr = 0; p_cal_act = 0; p_cal_first = 0;
        p_cal_el = 0; p_cal_tmr = 0; p_cal_cnt = 0; p_sum = 0; p_sumsq = 0;
        p_stats_valid = 0; p_last_ok = 0; p_mean = 0; p_sd = 0; p_last_n = 0;
    endtask

    function automatic event_t end_calibration();
        logic [63:0] n, mean, s2, ns, d, nn, var_q, sd;
        n = p_cal_cnt;
        p_cal_act = 0;
        p_last_n  = p_cal_cnt;
        if (n == 0 || p_cal_cnt < p_cmin)
        begin
            p_last_ok = 0;
            return EV_FAILED;
        end
        mean  = (({31'd0, p_sum} << 8) + n / 2) / n;
        s2    = {31'd0, p_sum} * {31'd0, p_sum};
        ns    = n * {11'd0, p_sumsq};
        d     = (ns > s2) ? ns - s2 : 0;
        nn    = n * n;
        var_q = ((d / nn) << 16) + (((d % nn) << 16) / nn);
        sd    = root_rounded(var_q);
        p_mean = mean[27:0];
        p_sd   = sd[27:0];
        p_stats_valid = 1;
        p_last_ok = 1;
        set_thr(thr_of(p_mean, p_sd, p_factor));
        return EV_DONE;
    endfunction

    // advance the predictor by one tick and return the expected status
    function automatic status_t predict_tick(tick_item_t it);
        status_t s;
        event_t  ev;
        logic    cand;
        ev = EV_NONE;
        p_samp_tmr = sat16(p_samp_tmr);
        p_chg_tmr  = sat16(p_chg_tmr);
        if (p_cal_act)
        begin
            p_cal_el  = sat16(p_cal_el);
            p_cal_tmr = sat16(p_cal_tmr);
        end
        case (it.func)
            FN_START:
            begin
                if (!p_cal_act)
                begin
                    p_cal_act = 1; p_cal_el = 0; p_cal_tmr = 0; p_cal_first = 1;
                    p_cal_cnt = 0; p_sum = 0; p_sumsq = 0;
                    ev = EV_STARTED;
                end
            end
            FN_CANCEL: p_cal_act = 0;
            FN_REAPPLY:
            begin
                if (p_stats_valid) set_thr(thr_of(p_mean, p_sd, p_factor));
            end
            FN_CLEAR:
            begin
                p_stats_valid = 0; p_mean = 0; p_sd = 0; p_factor = FACTOR_RESET;
                set_thr(p_init_thr);
            end
            default: ;
        endcase
        if (p_cal_act)
        begin
            if (p_cal_el >= p_cdur)
                ev = end_calibration();
            else if (p_cal_first || p_cal_tmr >= p_cper)
            begin
                p_cal_first = 0;
                p_cal_tmr = 0;
                p_last_raw = it.sample;
                if (p_cal_cnt < 13'd4096)
                begin
                    p_cal_cnt = p_cal_cnt + 13'd1;
                    p_sum   = p_sum + it.sample;
                    p_sumsq = p_sumsq + {33'd0, it.sample} * {33'd0, it.sample};
                end
            end
        end
        else if (p_samp_tmr >= p_sper)
        begin
            p_samp_tmr = 0;
            p_last_raw = it.sample;
            cand = it.sample > p_thr;
            if (cand != p_raw_lvl)
            begin
                p_raw_lvl = cand;
                p_chg_tmr = 0;
            end
            if (p_chg_tmr >= p_deb) p_pres_lvl = p_raw_lvl;
        end
        s.present = p_pres_lvl;
        s.raw_present = p_raw_lvl;
        s.calibrating = p_cal_act;
        s.event_res = ev;
        s.threshold_now = p_thr;
        s.mean_q8 = p_last_ok ? p_mean : 0;
        s.stddev_q8 = p_last_ok ? p_sd : 0;
        s.cal_samples_taken = p_last_n;
        s.cal_ok = p_last_ok;
        return s;
    endfunction

    // clock
    initial clk = 0;
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // input driver, holds an item until it has been taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 0;
        else if (!in_ch.valid || accepted_in == driven_cnt)
        begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_ch.valid      <= 1;
                in_ch.func       <= pending_ticks[0].func;
                in_ch.raw_sample <= pending_ticks[0].sample;
                driven_cnt       <= driven_cnt + 1;
            end
            else
                in_ch.valid <= 0;
        end
    end

    // accepted input: pop and predict
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            expected_status.push_back(predict_tick(pending_ticks.pop_front()));
            accepted_in <= accepted_in + 1;
        end
    end

    // result ready
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        status_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.present = out_ch.present;
            got.raw_present = out_ch.raw_present;
            got.calibrating = out_ch.calibrating;
            got.event_res = out_ch.event_res;
            got.threshold_now = out_ch.threshold_now;
            got.mean_q8 = out_ch.mean_q8;
            got.stddev_q8 = out_ch.stddev_q8;
            got.cal_samples_taken = out_ch.cal_samples_taken;
            got.cal_ok = out_ch.cal_ok;
            results_seen <= results_seen + 1;
            if (expected_status.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (want.event_res == EV_DONE) cal_done_seen++;
                if (want.event_res == EV_FAILED) cal_fail_seen++;
                if (got.present !== want.present)
                begin
                    $error("present exp %0d got %0d", want.present, got.present); errors++;
                end
                if (got.raw_present !== want.raw_present)
                begin
                    $error("raw_present exp %0d got %0d", want.raw_present, got.raw_present);
                    errors++;
                end
                if (got.calibrating !== want.calibrating)
                begin
                    $error("calibrating exp %0d got %0d", want.calibrating, got.calibrating);
                    errors++;
                end
                if (got.event_res !== want.event_res)
                begin
                    $error("event_res exp %0d got %0d", want.event_res, got.event_res); errors++;
                end
                if (got.threshold_now !== want.threshold_now)
                begin
                    $error("threshold_now exp %0d got %0d", want.threshold_now,
                           got.threshold_now);
                    errors++;
                end
                if (got.mean_q8 !== want.mean_q8)
                begin
                    $error("mean_q8 exp %0d got %0d", want.mean_q8, got.mean_q8); errors++;
                end
                if (got.stddev_q8 !== want.stddev_q8)
                begin
                    $error("stddev_q8 exp %0d got %0d", want.stddev_q8, got.stddev_q8); errors++;
                end
                if (got.cal_samples_taken !== want.cal_samples_taken)
                begin
                    $error("cal_samples_taken exp %0d got %0d", want.cal_samples_taken,
                           got.cal_samples_taken);
                    errors++;
                end
                if (got.cal_ok !== want.cal_ok)
                begin
                    $error("cal_ok exp %0d got %0d", want.cal_ok, got.cal_ok); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || expected_status.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        @(negedge clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            CFG_FACTOR:     p_factor = val[15:0];
            CFG_INIT_THR:   p_init_thr = val;
            CFG_SAMPLE_PER: p_sper = val[15:0];
            CFG_DEBOUNCE:   p_deb = val[15:0];
            CFG_CAL_DUR:    p_cdur = val[15:0];
            CFG_CAL_PER:    p_cper = val[15:0];
            CFG_CAL_MIN:    p_cmin = val[12:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    task automatic push_tick(logic [2:0] f, logic [19:0] s);
        tick_item_t t;
        t.func = f;
        t.sample = s;
        pending_ticks.push_back(t);
    endtask

    // mostly ticks, occasional commands, samples near a base level
    task automatic random_phase(int count, logic [19:0] base, int spread);
        int r;
        logic [19:0] s;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(9) == 0)
                s = 20'($urandom);
            else
                s = 20'(base + $urandom_range(spread));
            if (r < 80)      push_tick(FN_TICK, s);
            else if (r < 88) push_tick(FN_START, s);
            else if (r < 91) push_tick(FN_CANCEL, s);
            else if (r < 95) push_tick(FN_REAPPLY, s);
            else if (r < 97) push_tick(FN_CLEAR, s);
            else             push_tick(3'($urandom_range(7, 5)), s);
        end
    endtask

    initial
    begin
        errors = 0; accepted_in = 0; results_seen = 0; stall_cycles = 0;
        cal_done_seen = 0; cal_fail_seen = 0;
        idle_pct = 36;
        in_ch.valid = 0; in_ch.func = 0; in_ch.raw_sample = 0;
        out_ch.ready = 0;
        cfg.valid = 0; cfg.index = CFG_FACTOR; cfg.data = 0;
        reset_predictor();
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // short periods so runs end within a few dozen ticks
        write_reg(CFG_SAMPLE_PER, 24'd1);
        write_reg(CFG_DEBOUNCE, 24'd0);
        write_reg(CFG_CAL_DUR, 24'd8);
        write_reg(CFG_CAL_PER, 24'd0);
        write_reg(CFG_CAL_MIN, 24'd1);
        write_reg(CFG_FACTOR, 24'hFFFF);
        write_reg(CFG_INIT_THR, 24'd1);

        // directed: extremes, each command, full cycle of a run
        push_tick(FN_TICK, 20'hFFFFF);
        push_tick(FN_TICK, 20'h0);
        push_tick(FN_REAPPLY, 20'h5);
        push_tick(FN_CANCEL, 20'h5);
        push_tick(FN_START, 20'hFFFFF);
        push_tick(FN_START, 20'h0);
        for (int i = 0; i < 8; i++) push_tick(FN_TICK, 20'hFFFFF);
        push_tick(FN_REAPPLY, 20'h100);
        push_tick(FN_START, 20'h77);
        push_tick(FN_CANCEL, 20'h77);
        push_tick(FN_CLEAR, 20'hAAAAA);
        push_tick(FN_REAPPLY, 20'h55555);
        push_tick(3'd7, 20'h12345);
        push_tick(FN_START, 20'h9);
        for (int i = 0; i < 8; i++) push_tick(FN_TICK, 20'h9);
        wait_drained();

        // too few samples fails, zero duration ends at start
        write_reg(CFG_CAL_MIN, 24'd4096);
        write_reg(CFG_CAL_DUR, 24'd0);
        push_tick(FN_START, 20'h1);
        push_tick(FN_TICK, 20'h1);
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_FACTOR, (ph == 0) ? 24'd1 : 24'($urandom_range(65535, 1)));
            write_reg(CFG_INIT_THR,
                      (ph == 1) ? 24'hFFFFFF : 24'($urandom_range(1000000, 1)));
            write_reg(CFG_SAMPLE_PER, 24'($urandom_range(4, 1)));
            write_reg(CFG_DEBOUNCE, (ph == 2) ? 24'hFFFF : 24'($urandom_range(6)));
            write_reg(CFG_CAL_DUR, 24'($urandom_range(40, 5)));
            write_reg(CFG_CAL_PER, 24'($urandom_range(3, 1)));
            write_reg(CFG_CAL_MIN, 24'($urandom_range(6, 1)));
            idle_pct = (ph == 3) ? 0 : 36;
            random_phase(105, 20'($urandom), $urandom_range(4000));
            wait_drained();
        end

        $display("%0d items in, %0d results checked", accepted_in, results_seen);
        $display("%0d calibrations done, %0d failed", cal_done_seen, cal_fail_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
